// File: sv/bcl_pkg.sv
// Shared types and constants for the bounded circular list engine.
package bcl_pkg;

	localparam int CAPACITY_DEF   = 64;
	localparam int VALUE_BITS_DEF = 32;

	// Fixed widths of the stream fields
	localparam int ACT_W    = 3;
	localparam int DATA_W   = 32;
	localparam int POS_W    = 6;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;

	typedef enum logic [ACT_W-1:0] {
		ACT_INS_FRONT = 3'd0,
		ACT_INS_BACK  = 3'd1,
		ACT_REM_FRONT = 3'd2,
		ACT_REM_BACK  = 3'd3,
		ACT_REM_VALUE = 3'd4,
		ACT_SEARCH    = 3'd5
	} act_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ALLOC,
		S_LINK,
		S_WALK,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [COUNT_W-1:0]  element_count;
		logic [STATUS_W-1:0] status;
		logic [POS_W-1:0]    hit_position;
		logic                hit;
		logic [DATA_W-1:0]   out_value;
	} res_t;

endpackage

// File: sv/bcl_store.sv
// Slot store: value and next-link memories, one write port each, registered read.
module bcl_store #(
	parameter int CAPACITY   = bcl_pkg::CAPACITY_DEF,
	parameter int VALUE_BITS = bcl_pkg::VALUE_BITS_DEF,
	localparam int IDXW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  logic                         clk,
	input  logic [IDXW-1:0]              rd_addr,
	output logic signed [VALUE_BITS-1:0] rd_value,
	output logic [IDXW-1:0]              rd_link,
	input  logic                         val_we,
	input  logic [IDXW-1:0]              val_addr,
	input  logic signed [VALUE_BITS-1:0] val_data,
	input  logic                         link_we,
	input  logic [IDXW-1:0]              link_addr,
	input  logic [IDXW-1:0]              link_data
);

	logic signed [VALUE_BITS-1:0] val_mem [CAPACITY];
	logic [IDXW-1:0]              link_mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (val_we) begin
			val_mem[val_addr] <= val_data;
		end
		rd_value <= val_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[link_addr] <= link_data;
		end
		rd_link <= link_mem[rd_addr];
	end

endmodule

// File: sv/bcl_pool.sv
// Free-slot pool: stack of returned slots plus a counter of never-used slots.
module bcl_pool #(
	parameter int CAPACITY = bcl_pkg::CAPACITY_DEF,
	localparam int IDXW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
	localparam int CNTW    = $clog2(CAPACITY + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pop,       // slot valid on the next cycle
	input  logic            push,
	input  logic [IDXW-1:0] push_slot,
	output logic [IDXW-1:0] slot
);

	logic [IDXW-1:0] ret_mem [CAPACITY];
	logic [CNTW-1:0] ret_cnt_q;
	logic [CNTW-1:0] fresh_q;
	logic            from_ret_q;
	logic [IDXW-1:0] ret_rd_q;
	logic [IDXW-1:0] fresh_slot_q;
	logic [CNTW-1:0] ret_top;

	assign ret_top = ret_cnt_q - CNTW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ret_cnt_q  <= '0;
			fresh_q    <= '0;
			from_ret_q <= 1'b0;
		end else if (push) begin
			ret_cnt_q <= ret_cnt_q + CNTW'(1);
		end else if (pop) begin
			if (ret_cnt_q != '0) begin
				ret_cnt_q  <= ret_top;
				from_ret_q <= 1'b1;
			end else begin
				fresh_q    <= fresh_q + CNTW'(1);
				from_ret_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ret_mem[ret_cnt_q[IDXW-1:0]] <= push_slot;
		end
		ret_rd_q     <= ret_mem[ret_top[IDXW-1:0]];
		fresh_slot_q <= fresh_q[IDXW-1:0];
	end

	assign slot = from_ret_q ? ret_rd_q : fresh_slot_q;

endmodule

// File: sv/bcl_ctrl.sv
// Sequencer: decodes an operation and walks the list one link per cycle.
module bcl_ctrl #(
	parameter int CAPACITY   = bcl_pkg::CAPACITY_DEF,
	parameter int VALUE_BITS = bcl_pkg::VALUE_BITS_DEF,
	localparam int IDXW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
	localparam int CNTW      = $clog2(CAPACITY + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// operation in
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [bcl_pkg::ACT_W-1:0]    action,
	input  logic signed [bcl_pkg::DATA_W-1:0] item_value,
	// result out
	output logic                         res_valid,
	input  logic                         res_ack,
	output bcl_pkg::res_t                res,
	// slot store
	output logic [IDXW-1:0]              rd_addr,
	input  logic signed [VALUE_BITS-1:0] rd_value,
	input  logic [IDXW-1:0]              rd_link,
	output logic                         val_we,
	output logic [IDXW-1:0]              val_addr,
	output logic signed [VALUE_BITS-1:0] val_data,
	output logic                         link_we,
	output logic [IDXW-1:0]              link_addr,
	output logic [IDXW-1:0]              link_data,
	// free pool
	output logic                         pool_pop,
	output logic                         pool_push,
	output logic [IDXW-1:0]              pool_push_slot,
	input  logic [IDXW-1:0]              pool_slot
);

	bcl_pkg::state_t state_q, state_n;
	bcl_pkg::act_t   act_q, act_n;
	bcl_pkg::res_t   res_q, res_n;
	logic signed [VALUE_BITS-1:0] key_q, key_n;
	logic [IDXW-1:0] head_q, head_n, tail_q, tail_n;
	logic [IDXW-1:0] cur_q, cur_n, prev_q, prev_n, idx_q, idx_n;
	logic [CNTW-1:0] used_q, used_n;

	logic signed [63:0] in_ext;
	logic signed [63:0] rd_ext;
	logic               is_last, is_match, is_target;

	assign in_ext = 64'(item_value);
	assign rd_ext = 64'(rd_value);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bcl_pkg::S_IDLE;
			used_q  <= '0;
			head_q  <= '0;
			tail_q  <= '0;
		end else begin
			state_q <= state_n;
			used_q  <= used_n;
			head_q  <= head_n;
			tail_q  <= tail_n;
		end
	end

	always_ff @(posedge clk) begin
		act_q  <= act_n;
		key_q  <= key_n;
		res_q  <= res_n;
		cur_q  <= cur_n;
		prev_q <= prev_n;
		idx_q  <= idx_n;
	end

	always_comb begin
		is_last  = (CNTW'(idx_q) == used_q - CNTW'(1));
		is_match = (rd_value == key_q)
			&& (act_q == bcl_pkg::ACT_REM_VALUE || act_q == bcl_pkg::ACT_SEARCH);
		case (act_q)
			bcl_pkg::ACT_REM_FRONT: is_target = 1'b1;
			bcl_pkg::ACT_REM_BACK:  is_target = is_last;
			default:                is_target = is_match;
		endcase
	end

	always_comb begin
		state_n = state_q;
		act_n   = act_q;
		key_n   = key_q;
		res_n   = res_q;
		head_n  = head_q;
		tail_n  = tail_q;
		cur_n   = cur_q;
		prev_n  = prev_q;
		idx_n   = idx_q;
		used_n  = used_q;

		in_ready       = (state_q == bcl_pkg::S_IDLE);
		res_valid      = (state_q == bcl_pkg::S_DONE);
		rd_addr        = head_q;
		val_we         = 1'b0;
		val_addr       = pool_slot;
		val_data       = key_q;
		link_we        = 1'b0;
		link_addr      = tail_q;
		link_data      = cur_q;
		pool_pop       = 1'b0;
		pool_push      = 1'b0;
		pool_push_slot = cur_q;

		res          = res_q;
		res.element_count = bcl_pkg::COUNT_W'(used_q);

		case (state_q)
			bcl_pkg::S_IDLE: begin
				if (in_valid) begin
					act_n  = bcl_pkg::act_t'(action);
					key_n  = in_ext[VALUE_BITS-1:0];
					res_n  = '0;
					cur_n  = head_q;
					prev_n = tail_q;   // list is circular: the head's predecessor is the tail
					idx_n  = '0;
					case (action)
						bcl_pkg::ACT_INS_FRONT, bcl_pkg::ACT_INS_BACK: begin
							if (used_q == CNTW'(CAPACITY)) begin
								res_n.status = bcl_pkg::STAT_FULL;
								state_n      = bcl_pkg::S_DONE;
							end else begin
								pool_pop = 1'b1;
								state_n  = bcl_pkg::S_ALLOC;
							end
						end
						bcl_pkg::ACT_REM_FRONT, bcl_pkg::ACT_REM_BACK,
						bcl_pkg::ACT_REM_VALUE: begin
							if (used_q == '0) begin
								res_n.status = bcl_pkg::STAT_EMPTY;
								state_n      = bcl_pkg::S_DONE;
							end else begin
								state_n = bcl_pkg::S_WALK;
							end
						end
						bcl_pkg::ACT_SEARCH: begin
							state_n = (used_q == '0) ? bcl_pkg::S_DONE : bcl_pkg::S_WALK;
						end
						default: begin
							state_n = bcl_pkg::S_DONE;
						end
					endcase
				end
			end

			bcl_pkg::S_ALLOC: begin
				val_we    = 1'b1;
				link_we   = 1'b1;
				link_addr = pool_slot;
				link_data = (used_q == '0) ? pool_slot : head_q;
				cur_n     = pool_slot;
				if (used_q == '0) begin
					head_n  = pool_slot;
					tail_n  = pool_slot;
					used_n  = used_q + CNTW'(1);
					state_n = bcl_pkg::S_DONE;
				end else begin
					state_n = bcl_pkg::S_LINK;
				end
			end

			bcl_pkg::S_LINK: begin
				link_we   = 1'b1;
				link_addr = tail_q;
				link_data = cur_q;
				if (act_q == bcl_pkg::ACT_INS_FRONT) begin
					head_n = cur_q;
				end else begin
					tail_n = cur_q;
				end
				used_n  = used_q + CNTW'(1);
				state_n = bcl_pkg::S_DONE;
			end

			bcl_pkg::S_WALK: begin
				// rd_value / rd_link belong to cur_q
				if (is_target) begin
					if (act_q == bcl_pkg::ACT_REM_FRONT || act_q == bcl_pkg::ACT_REM_BACK) begin
						res_n.out_value = rd_ext[bcl_pkg::DATA_W-1:0];
					end else begin
						res_n.hit          = 1'b1;
						res_n.hit_position = bcl_pkg::POS_W'(idx_q);
					end
					if (act_q != bcl_pkg::ACT_SEARCH) begin
						// unlink cur_q
						link_we   = (used_q != CNTW'(1));
						link_addr = prev_q;
						link_data = rd_link;
						if (cur_q == head_q) begin
							head_n = rd_link;
						end
						if (cur_q == tail_q) begin
							tail_n = prev_q;
						end
						pool_push = 1'b1;
						used_n    = used_q - CNTW'(1);
					end
					state_n = bcl_pkg::S_DONE;
				end else if (is_last) begin
					state_n = bcl_pkg::S_DONE;
				end else begin
					rd_addr = rd_link;
					prev_n  = cur_q;
					cur_n   = rd_link;
					idx_n   = idx_q + IDXW'(1);
				end
			end

			bcl_pkg::S_DONE: begin
				if (res_ack) begin
					state_n = bcl_pkg::S_IDLE;
				end
			end

			default: begin
				state_n = bcl_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// File: sv/bounded_circular_list_engine_top.sv
// Top level of the bounded circular list engine.
//
// Keeps an ordered list of up to CAPACITY signed values as a circular singly
// linked list in a slot store, with a free-slot pool. One operation is taken
// per transfer on the s_axis side (tuser = action, tdata = item_value) and
// exactly one result transfer follows on m_axis. Operations are handled one
// at a time; s_axis_tready is high only while the sequencer is idle. An
// insert takes a free slot, writes it (S_ALLOC) and links it in (S_LINK,
// skipped for an empty list). Removes and searches walk from the head up
// to the target: the head for remove front, the last element for remove
// back, the first match for search and remove value, else the last element.
// Full, empty and unused action codes go straight to the result. The walk
// advances one link per cycle, set by the single registered read port of
// the slot store. The output register lets the next operation be accepted
// while a result is still waiting on m_axis. After reset the list is empty
// and the block is ready at once; no memory clearing pass is needed.
module bounded_circular_list_engine_top #(
	parameter int CAPACITY   = bcl_pkg::CAPACITY_DEF,
	parameter int VALUE_BITS = bcl_pkg::VALUE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// operation stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] item_value
	input  logic [2:0]  s_axis_tuser,   // [2:0] action
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata    // [31:0] out_value, [32] hit,
	                                    // [38:33] hit_position, [40:39] status,
	                                    // [47:41] element_count
);

	localparam int IDXW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	logic                         res_valid;
	logic                         res_ack;
	bcl_pkg::res_t                res;
	logic [IDXW-1:0]              rd_addr;
	logic signed [VALUE_BITS-1:0] rd_value;
	logic [IDXW-1:0]              rd_link;
	logic                         val_we;
	logic [IDXW-1:0]              val_addr;
	logic signed [VALUE_BITS-1:0] val_data;
	logic                         link_we;
	logic [IDXW-1:0]              link_addr;
	logic [IDXW-1:0]              link_data;
	logic                         pool_pop;
	logic                         pool_push;
	logic [IDXW-1:0]              pool_push_slot;
	logic [IDXW-1:0]              pool_slot;

	logic                         out_valid_q;
	bcl_pkg::res_t                out_res_q;

	bcl_ctrl #(
		.CAPACITY   (CAPACITY),
		.VALUE_BITS (VALUE_BITS)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_axis_tvalid),
		.in_ready       (s_axis_tready),
		.action         (s_axis_tuser),
		.item_value     (s_axis_tdata),
		.res_valid      (res_valid),
		.res_ack        (res_ack),
		.res            (res),
		.rd_addr        (rd_addr),
		.rd_value       (rd_value),
		.rd_link        (rd_link),
		.val_we         (val_we),
		.val_addr       (val_addr),
		.val_data       (val_data),
		.link_we        (link_we),
		.link_addr      (link_addr),
		.link_data      (link_data),
		.pool_pop       (pool_pop),
		.pool_push      (pool_push),
		.pool_push_slot (pool_push_slot),
		.pool_slot      (pool_slot)
	);

	bcl_store #(
		.CAPACITY   (CAPACITY),
		.VALUE_BITS (VALUE_BITS)
	) u_store (
		.clk       (clk),
		.rd_addr   (rd_addr),
		.rd_value  (rd_value),
		.rd_link   (rd_link),
		.val_we    (val_we),
		.val_addr  (val_addr),
		.val_data  (val_data),
		.link_we   (link_we),
		.link_addr (link_addr),
		.link_data (link_data)
	);

	bcl_pool #(
		.CAPACITY (CAPACITY)
	) u_pool (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop       (pool_pop),
		.push      (pool_push),
		.push_slot (pool_push_slot),
		.slot      (pool_slot)
	);

	// Output register: loads when empty or when the held result transfers.
	assign res_ack = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ack) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ack) begin
			out_res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_res_q;

endmodule
